// ===== design/qxm_pkg.sv =====
// ----------------------------------------------------------------------------
// qxm_pkg
// Shared constants, types and the divider step for the quad-X motor mixer.
// ----------------------------------------------------------------------------
package qxm_pkg;

  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned CMD_W     = 18;               // command field width
  localparam int unsigned MOT_W     = 16;               // motor field width
  localparam int unsigned SUM_W     = CMD_W + 1;        // doubled motor sum, signed
  localparam int unsigned DIV_W     = CMD_W;            // divisor and remainder width
  localparam int unsigned Q_W       = FRAC_BITS + 1;    // quotient bits, result <= ONE
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = Q_W / STEPS_PER_STAGE;
  localparam int unsigned NUM_MOT   = 4;

  localparam logic signed [CMD_W-1:0] ONE_C    = CMD_W'(1 << FRAC_BITS);
  localparam logic signed [CMD_W-1:0] NEG_ONE_C = -ONE_C;
  localparam logic signed [SUM_W-1:0] TWO_ONE_S = SUM_W'(2 << FRAC_BITS);

  typedef logic signed [SUM_W-1:0] sum_t;

  // mix stage result: the four doubled sums
  typedef struct packed {
    sum_t [NUM_MOT-1:0] m;
  } mix_bus_t;

  // per-motor state of the long division
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic             nbit;     // next dividend bit to shift in
    logic [Q_W-1:0]   quo;
  } div_lane_t;

  typedef struct packed {
    logic [DIV_W-1:0]              divisor;
    logic                          scale;
    div_lane_t [NUM_MOT-1:0]       lane;
    logic [NUM_MOT-1:0][MOT_W-1:0] direct;
  } div_bus_t;

  // one restoring division step: shift a bit in, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t l, logic [DIV_W-1:0] d);
    logic [DIV_W:0] sh;
    logic [DIV_W:0] diff;
    div_lane_t      r;
    sh   = {l.rem, l.nbit};
    diff = sh - {1'b0, d};
    r.nbit = 1'b0;
    if (sh >= {1'b0, d}) begin
      r.rem = diff[DIV_W-1:0];
      r.quo = {l.quo[Q_W-2:0], 1'b1};
    end else begin
      r.rem = sh[DIV_W-1:0];
      r.quo = {l.quo[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== design/qxm_mix.sv =====
// ----------------------------------------------------------------------------
// qxm_mix
// Clamp the four commands and form the doubled X-pattern motor sums.
// ----------------------------------------------------------------------------
module qxm_mix import qxm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    armed_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [CMD_W-1:0] throttle_i,
  input  logic signed [CMD_W-1:0] roll_i,
  input  logic signed [CMD_W-1:0] pitch_i,
  input  logic signed [CMD_W-1:0] yaw_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output mix_bus_t                data_o
);

  logic                    valid_q;
  mix_bus_t                data_q, data_d;
  logic signed [CMD_W-1:0] t, r, p, y;

  function automatic logic signed [CMD_W-1:0] clamp(logic signed [CMD_W-1:0] v,
                                                    logic signed [CMD_W-1:0] lo);
    logic signed [CMD_W-1:0] res;
    res = v;
    if (v < lo) begin
      res = lo;
    end else if (v > ONE_C) begin
      res = ONE_C;
    end
    return res;
  endfunction

  // a disarmed block mixes zeros, which yields zero on every motor
  always_comb begin
    t = '0;
    r = '0;
    p = '0;
    y = '0;
    if (armed_i) begin
      t = clamp(throttle_i, '0);
      r = clamp(roll_i, NEG_ONE_C);
      p = clamp(pitch_i, NEG_ONE_C);
      y = clamp(yaw_i, NEG_ONE_C);
    end
    data_d.m[0] = (SUM_W'(t) <<< 1) + SUM_W'(p) + SUM_W'(r) - SUM_W'(y);
    data_d.m[1] = (SUM_W'(t) <<< 1) + SUM_W'(p) - SUM_W'(r) + SUM_W'(y);
    data_d.m[2] = (SUM_W'(t) <<< 1) - SUM_W'(p) - SUM_W'(r) - SUM_W'(y);
    data_d.m[3] = (SUM_W'(t) <<< 1) - SUM_W'(p) + SUM_W'(r) + SUM_W'(y);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/qxm_peak.sv =====
// ----------------------------------------------------------------------------
// qxm_peak
// Find the largest sum, decide on scaling and set up the division lanes.
// ----------------------------------------------------------------------------
module qxm_peak import qxm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  mix_bus_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output div_bus_t data_o
);

  logic     valid_q;
  div_bus_t data_q, data_d;
  sum_t     max01, max23, peak;
  logic [DIV_W-1:0] pos;

  always_comb begin
    max01 = (data_i.m[1] > data_i.m[0]) ? data_i.m[1] : data_i.m[0];
    max23 = (data_i.m[3] > data_i.m[2]) ? data_i.m[3] : data_i.m[2];
    peak  = (max23 > max01) ? max23 : max01;
    data_d.divisor = peak[DIV_W-1:0];
    data_d.scale   = peak > TWO_ONE_S;
    pos = '0;
    for (int i = 0; i < NUM_MOT; i++) begin
      // negative sums end at zero either way
      pos = (data_i.m[i] > 0) ? data_i.m[i][DIV_W-1:0] : '0;
      // dividend is pos << FRAC_BITS: its top part seeds the remainder
      data_d.lane[i].rem  = pos >> 1;
      data_d.lane[i].nbit = pos[0];
      data_d.lane[i].quo  = '0;
      data_d.direct[i]    = MOT_W'(pos >> 1);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/qxm_div_stage.sv =====
// ----------------------------------------------------------------------------
// qxm_div_stage
// One pipeline stage of the four-lane restoring divider, two quotient bits.
// ----------------------------------------------------------------------------
module qxm_div_stage import qxm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  div_bus_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output div_bus_t data_o
);

  logic      valid_q;
  div_bus_t  data_q, data_d;
  div_lane_t step_lane;

  always_comb begin
    data_d    = data_i;
    step_lane = '0;
    for (int i = 0; i < NUM_MOT; i++) begin
      step_lane = data_i.lane[i];
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        step_lane = div_step(step_lane, data_i.divisor);
      end
      data_d.lane[i] = step_lane;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/quad_x_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// Quad-X motor mixer: clamp, mix, scale by an overrange peak, clamp to 0..1.
// ----------------------------------------------------------------------------
// Pipeline: mix, peak, 8 divider stages of 2 quotient bits each, output
//   register.
// Throughput: one request per cycle while not stalled; every stage has its
//   own valid bit, and an output stall only fills bubbles ahead of it.
// Reset: asynchronous, active low; clears all valid bits and disarms.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer import qxm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // throttle_cmd[17:0], roll_cmd[35:18], pitch_cmd[53:36], yaw_cmd[71:54]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motor_front_a[15:0], motor_front_b[31:16], motor_rear_a[47:32],
  // motor_rear_b[63:48]
  output logic [63:0] m_axis_tdata
);

  logic armed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else if (cfg_we_i) begin
      armed_q <= cfg_wdata_i;
    end
  end

  logic     mix_valid, mix_ready;
  mix_bus_t mix_data;

  qxm_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .armed_i    (armed_q),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .throttle_i (s_axis_tdata[17:0]),
    .roll_i     (s_axis_tdata[35:18]),
    .pitch_i    (s_axis_tdata[53:36]),
    .yaw_i      (s_axis_tdata[71:54]),
    .valid_o    (mix_valid),
    .ready_i    (mix_ready),
    .data_o     (mix_data)
  );

  logic     [DIV_STAGES:0] div_valid, div_ready;
  div_bus_t [DIV_STAGES:0] div_data;

  qxm_peak u_peak (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .ready_o (mix_ready),
    .data_i  (mix_data),
    .valid_o (div_valid[0]),
    .ready_i (div_ready[0]),
    .data_o  (div_data[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    qxm_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .ready_o (div_ready[k]),
      .data_i  (div_data[k]),
      .valid_o (div_valid[k+1]),
      .ready_i (div_ready[k+1]),
      .data_o  (div_data[k+1])
    );
  end

  // output register: pick the scaled quotient or the plain halved sum
  logic        out_valid_q;
  logic [63:0] out_data_q, out_data_d;

  always_comb begin
    for (int i = 0; i < NUM_MOT; i++) begin
      out_data_d[i*MOT_W +: MOT_W] = div_data[DIV_STAGES].scale
                                   ? MOT_W'(div_data[DIV_STAGES].lane[i].quo)
                                   : div_data[DIV_STAGES].direct[i];
    end
  end

  assign div_ready[DIV_STAGES] = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready[DIV_STAGES]) begin
      out_valid_q <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready[DIV_STAGES] && div_valid[DIV_STAGES]) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
